// ----- rtl/bc1d_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and palette helpers for the BC1 block decoder.
// No dependencies.
package bc1d_pkg;

	localparam int MAX_DIMENSION = 16384;
	localparam int DIM_W         = 15;
	localparam int BLK_CNT_W     = 13;
	localparam int POS_W         = 12;
	localparam int COORD_W       = 14;
	localparam int INDEX_W       = 28;
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W     = 2;
	localparam int TEXELS        = 16;
	localparam int TEXEL_W       = $clog2(TEXELS);

	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1024);
	localparam logic [DIM_W-1:0] DIM_MAX   = DIM_W'(MAX_DIMENSION);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} rgba_t;

	typedef struct packed {
		rgba_t [3:0]        palette;
		logic [31:0]        indices;
		logic [POS_W-1:0]   col;
		logic [POS_W-1:0]   row;
		logic               final_blk;
		logic [INDEX_W-1:0] row_base;
	} blk_t;

	function automatic rgba_t expand565(input logic [15:0] c);
		rgba_t o;
		o.r = {c[15:11], c[15:13]};
		o.g = {c[10:5], c[10:9]};
		o.b = {c[4:0], c[4:2]};
		o.a = 8'd255;
		return o;
	endfunction

	// floor(v/3) for v < 768 via reciprocal 683/2048
	function automatic logic [7:0] div3(input logic [9:0] v);
		logic [19:0] prod;
		prod = 20'(v) * 20'd683;
		return prod[18:11];
	endfunction

	function automatic logic [7:0] third(input logic [7:0] near, input logic [7:0] far);
		logic [9:0] sum;
		sum = {1'b0, near, 1'b0} + {2'b00, far};
		return div3(sum);
	endfunction

	function automatic logic [7:0] half(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[8:1];
	endfunction

endpackage

// ----- rtl/bc1d_queue.sv -----
`timescale 1ns / 1ps
// Small FIFO of decoded block descriptors between front and back.
// Depends on bc1d_pkg.
module bc1d_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bc1d_pkg::blk_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output bc1d_pkg::blk_t pop_data
);
	import bc1d_pkg::*;

	blk_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue pop while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

// ----- rtl/bc1d_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts blocks, builds the palette, tracks block position.
// Depends on bc1d_pkg; feeds bc1d_queue.
module bc1d_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [15:0]              endpoint_color0,
	input  logic [15:0]              endpoint_color1,
	input  logic [31:0]              texel_indices,
	input  logic [bc1d_pkg::DIM_W-1:0]     width_eff,
	input  logic [bc1d_pkg::BLK_CNT_W-1:0] blk_cols,
	input  logic [bc1d_pkg::BLK_CNT_W-1:0] blk_rows,
	input  logic                     restart,
	input  logic                     q_full,
	output logic                     q_push,
	output bc1d_pkg::blk_t           q_data
);
	import bc1d_pkg::*;

	logic [POS_W-1:0]   col_q;
	logic [POS_W-1:0]   row_q;
	logic [POS_W-1:0]   col_inc;
	logic [POS_W-1:0]   row_inc;
	logic               empty_img;
	logic               accept;
	rgba_t              e0;
	rgba_t              e1;
	rgba_t              p2;
	rgba_t              p3;
	logic [INDEX_W-1:0] prod;

	assign in_stall  = q_full;
	assign accept    = in_valid && !in_stall;
	assign empty_img = (blk_cols == '0) || (blk_rows == '0);
	assign q_push    = accept && !empty_img;
	assign col_inc   = col_q + 1'b1;
	assign row_inc   = row_q + 1'b1;
	assign prod      = INDEX_W'({row_q, 2'b00}) * INDEX_W'(width_eff);

	always_comb begin
		e0 = expand565(endpoint_color0);
		e1 = expand565(endpoint_color1);
		if (endpoint_color0 > endpoint_color1) begin
			p2 = '{r: third(e0.r, e1.r), g: third(e0.g, e1.g), b: third(e0.b, e1.b),
				a: 8'd255};
			p3 = '{r: third(e1.r, e0.r), g: third(e1.g, e0.g), b: third(e1.b, e0.b),
				a: 8'd255};
		end else begin
			p2 = '{r: half(e0.r, e1.r), g: half(e0.g, e1.g), b: half(e0.b, e1.b),
				a: 8'd255};
			p3 = '0;
		end
		q_data.palette   = {p3, p2, e1, e0};
		q_data.indices   = texel_indices;
		q_data.col       = col_q;
		q_data.row       = row_q;
		q_data.final_blk = ({1'b0, col_q} + 1'b1 >= blk_cols) &&
			({1'b0, row_q} + 1'b1 >= blk_rows);
		q_data.row_base  = prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (q_push) begin
			if (({1'b0, col_inc} >= blk_cols) || (col_inc == '0)) begin
				col_q <= '0;
				row_q <= ({1'b0, row_inc} >= blk_rows) ? '0 : row_inc;
			end else begin
				col_q <= col_inc;
			end
		end
	end

endmodule

// ----- rtl/bc1d_back.sv -----
`timescale 1ns / 1ps
// Back end: walks the sixteen texels of a queued block into the output register.
// Depends on bc1d_pkg; drains bc1d_queue.
module bc1d_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [bc1d_pkg::DIM_W-1:0]   width_eff,
	input  logic                         q_not_empty,
	input  bc1d_pkg::blk_t               q_data,
	output logic                         q_pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [bc1d_pkg::COORD_W-1:0] pixel_x,
	output logic [bc1d_pkg::COORD_W-1:0] pixel_y,
	output logic [bc1d_pkg::INDEX_W-1:0] pixel_index,
	output logic [7:0]                   red,
	output logic [7:0]                   green,
	output logic [7:0]                   blue,
	output logic [7:0]                   alpha,
	output logic                         last_of_block,
	output logic                         last_of_image
);
	import bc1d_pkg::*;

	blk_t               blk_q;
	logic               busy_q;
	logic [TEXEL_W-1:0] k_q;
	logic [INDEX_W-1:0] row_base_q;
	logic               out_valid_q;
	logic               fire;
	logic               done;
	logic [1:0]         sel;
	rgba_t              texel;
	logic [COORD_W-1:0] x;
	logic [COORD_W-1:0] y;

	assign fire      = busy_q && (!out_valid_q || !out_stall);
	assign done      = fire && (k_q == TEXEL_W'(TEXELS - 1));
	assign q_pop     = q_not_empty && (!busy_q || done);
	assign sel       = blk_q.indices[{k_q, 1'b0} +: 2];
	assign texel     = blk_q.palette[sel];
	assign x         = {blk_q.col, k_q[1:0]};
	assign y         = {blk_q.row, k_q[3:2]};
	assign out_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			blk_q <= q_data;
		end
		if (fire) begin
			pixel_x       <= x;
			pixel_y       <= y;
			pixel_index   <= row_base_q + INDEX_W'(x);
			red           <= texel.r;
			green         <= texel.g;
			blue          <= texel.b;
			alpha         <= texel.a;
			last_of_block <= done;
			last_of_image <= done && blk_q.final_blk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			k_q         <= '0;
			row_base_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q     <= 1'b1;
				k_q        <= '0;
				row_base_q <= q_data.row_base;
			end else if (fire) begin
				busy_q <= !done;
				k_q    <= k_q + 1'b1;
				if (k_q[1:0] == 2'd3) begin
					row_base_q <= row_base_q + INDEX_W'(width_eff);
				end
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last_of_block |-> pixel_x[1:0] == 2'd3 && pixel_y[1:0] == 2'd3)
		else $error("block end off its last texel");

	a_image_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last_of_image |-> last_of_block)
		else $error("image end not at block end");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> busy_q && k_q == '0)
		else $error("block load did not restart texel walk");

endmodule

// ----- rtl/bc1_block_decoder.sv -----
`timescale 1ns / 1ps
// Top level of the BC1 block decoder: configuration registers, front, queue, back.
// Depends on bc1d_pkg, bc1d_front, bc1d_queue, bc1d_back.
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------------
//  in      | in_valid / in_stall | endpoint_color0, endpoint_color1, texel_indices
//  out     | out_valid/out_stall | pixel_x, pixel_y, pixel_index, red..alpha, last_*
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Each block beat yields sixteen texel beats, one per cycle while out_stall is low,
// from a single output register; the texel counter in the back end counts them.
// Blocks pass a queue entry and the back-end block register on the way out; a two-entry
// queue lets blocks overlap. Blocks taken while width/4 or height/4 is zero yield nothing.
// Reset restores 1024 x 1024 and block (0,0); a register write restarts the walk.
// out_stall holds the output register and backs up through the queue to in_stall.
module bc1_block_decoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [15:0]                    endpoint_color0,
	input  logic [15:0]                    endpoint_color1,
	input  logic [31:0]                    texel_indices,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [bc1d_pkg::COORD_W-1:0]   pixel_x,
	output logic [bc1d_pkg::COORD_W-1:0]   pixel_y,
	output logic [bc1d_pkg::INDEX_W-1:0]   pixel_index,
	output logic [7:0]                     red,
	output logic [7:0]                     green,
	output logic [7:0]                     blue,
	output logic [7:0]                     alpha,
	output logic                           last_of_block,
	output logic                           last_of_image,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bc1d_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bc1d_pkg::DIM_W-1:0]     cfg_data
);
	import bc1d_pkg::*;

	logic [DIM_W-1:0]     width_q;
	logic [DIM_W-1:0]     height_q;
	logic [DIM_W-1:0]     width_eff;
	logic [DIM_W-1:0]     height_eff;
	logic                 cfg_wr;
	logic                 restart;
	logic                 q_push;
	logic                 q_full;
	logic                 q_pop;
	logic                 q_not_empty;
	blk_t                 q_in;
	blk_t                 q_out;

	assign cfg_ready  = 1'b1;
	assign cfg_wr     = cfg_valid && cfg_ready;
	assign width_eff  = (width_q > DIM_MAX) ? DIM_MAX : width_q;
	assign height_eff = (height_q > DIM_MAX) ? DIM_MAX : height_q;

	always_comb begin
		unique case (cfg_index) inside
			REG_IMAGE_WIDTH,
			REG_IMAGE_HEIGHT: restart = cfg_wr;
			default:          restart = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bc1d_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.endpoint_color0 (endpoint_color0),
		.endpoint_color1 (endpoint_color1),
		.texel_indices   (texel_indices),
		.width_eff       (width_eff),
		.blk_cols        (width_eff[DIM_W-1:2]),
		.blk_rows        (height_eff[DIM_W-1:2]),
		.restart         (restart),
		.q_full          (q_full),
		.q_push          (q_push),
		.q_data          (q_in)
	);

	bc1d_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (q_out)
	);

	bc1d_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.width_eff     (width_eff),
		.q_not_empty   (q_not_empty),
		.q_data        (q_out),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.pixel_index   (pixel_index),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.alpha         (alpha),
		.last_of_block (last_of_block),
		.last_of_image (last_of_image)
	);

endmodule
